@@ rtl/qxmm_pkg.sv @@
// ----------------------------------------------------------------------------
// qxmm_pkg
// Shared constants and types for the quad X-frame motor mixer: fixed point
// format, pipeline depth, register map and register reset values.
// ----------------------------------------------------------------------------
package qxmm_pkg;

   // fixed point format, one = 1 << FRAC_BITS
   localparam int unsigned FRAC_BITS  = 14;
   localparam int unsigned NUM_MOTORS = 4;
   localparam int unsigned DRIVE_W    = 15;
   localparam logic [DRIVE_W-1:0] DRIVE_ONE = DRIVE_W'(1 << FRAC_BITS);

   // register stages from input to output register
   localparam int unsigned PIPE_STAGES = 7;

   // register map, register i at byte address 8*i
   typedef enum logic [2:0] {
      REG_START_FACTOR  = 3'd0,
      REG_MID_FACTOR    = 3'd1,
      REG_MID_POINT     = 3'd2,
      REG_LOW_SLOPE     = 3'd3,
      REG_HIGH_SLOPE    = 3'd4,
      REG_MOTOR_GAINS   = 3'd5,
      REG_MOTOR_OFFSETS = 3'd6
   } csr_index_type;

   // register reset values
   localparam logic [15:0] START_FACTOR_RST  = 16'h4000;
   localparam logic [15:0] MID_FACTOR_RST    = 16'h4000;
   localparam logic [13:0] MID_POINT_RST     = 14'h2000;
   localparam logic [19:0] LOW_SLOPE_RST     = 20'h0_0000;
   localparam logic [19:0] HIGH_SLOPE_RST    = 20'h0_0000;
   localparam logic [63:0] MOTOR_GAINS_RST   = 64'h4000_4000_4000_4000;
   localparam logic [63:0] MOTOR_OFFSETS_RST = 64'h0000_0000_0000_0000;

endpackage

@@ rtl/quad_x_motor_mixer_unit.sv @@
// ----------------------------------------------------------------------------
// quad_x_motor_mixer_unit
// Stateless X-frame quadcopter mixer. One control sample per clock, while
// rsp is not stalled, goes through a seven stage pipeline: segment select,
// slope multiply, gain add, roll/pitch attenuation multiply, motor mix,
// per-motor gain multiply, and offset plus clamp into the output register.
// The sustained rate is one beat per clock while rsp_tready stays high, set
// by the multipliers each having a stage of their own. Every stage has its
// own valid bit and loads whenever it is empty or its content moves on, so
// bubbles are squeezed out under rsp backpressure and req_tready only drops
// when all seven stages hold a result. Registers must be written through
// the csr port only while the pipeline is empty; the block itself does not
// enforce this.
// ----------------------------------------------------------------------------
module quad_x_motor_mixer_unit (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // throttle[14:0] roll[30:15] pitch[46:31] yaw[62:47]
   input  logic        req_tuser,  // armed
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // front_left[14:0] rear_right[29:15]
                                   // rear_left[44:30] front_right[59:45]
   output logic        rsp_tuser,  // disarmed_error
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   localparam int unsigned NS = qxmm_pkg::PIPE_STAGES;
   localparam int unsigned FB = qxmm_pkg::FRAC_BITS;
   localparam int unsigned NM = qxmm_pkg::NUM_MOTORS;
   localparam int unsigned DW = qxmm_pkg::DRIVE_W;

   // ------------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------------
   logic [15:0] start_factor_ff;
   logic [15:0] mid_factor_ff;
   logic [13:0] mid_point_ff;
   logic [19:0] low_slope_ff;
   logic [19:0] high_slope_ff;
   logic [63:0] motor_gains_ff;
   logic [63:0] motor_offsets_ff;

   qxmm_pkg::csr_index_type csr_index;
   logic                    csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = qxmm_pkg::csr_index_type'(csr_paddr[5:3]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // register write
   always_ff @(posedge clock) begin
      if (reset) begin
         start_factor_ff  <= qxmm_pkg::START_FACTOR_RST;
         mid_factor_ff    <= qxmm_pkg::MID_FACTOR_RST;
         mid_point_ff     <= qxmm_pkg::MID_POINT_RST;
         low_slope_ff     <= qxmm_pkg::LOW_SLOPE_RST;
         high_slope_ff    <= qxmm_pkg::HIGH_SLOPE_RST;
         motor_gains_ff   <= qxmm_pkg::MOTOR_GAINS_RST;
         motor_offsets_ff <= qxmm_pkg::MOTOR_OFFSETS_RST;
      end else if (csr_write) begin
         case (csr_index)
            qxmm_pkg::REG_START_FACTOR:  start_factor_ff  <= csr_pwdata[15:0];
            qxmm_pkg::REG_MID_FACTOR:    mid_factor_ff    <= csr_pwdata[15:0];
            qxmm_pkg::REG_MID_POINT:     mid_point_ff     <= csr_pwdata[13:0];
            qxmm_pkg::REG_LOW_SLOPE:     low_slope_ff     <= csr_pwdata[19:0];
            qxmm_pkg::REG_HIGH_SLOPE:    high_slope_ff    <= csr_pwdata[19:0];
            qxmm_pkg::REG_MOTOR_GAINS:   motor_gains_ff   <= csr_pwdata;
            qxmm_pkg::REG_MOTOR_OFFSETS: motor_offsets_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   // register read
   always_comb begin
      case (csr_index)
         qxmm_pkg::REG_START_FACTOR:  csr_prdata = {48'b0, start_factor_ff};
         qxmm_pkg::REG_MID_FACTOR:    csr_prdata = {48'b0, mid_factor_ff};
         qxmm_pkg::REG_MID_POINT:     csr_prdata = {50'b0, mid_point_ff};
         qxmm_pkg::REG_LOW_SLOPE:     csr_prdata = {44'b0, low_slope_ff};
         qxmm_pkg::REG_HIGH_SLOPE:    csr_prdata = {44'b0, high_slope_ff};
         qxmm_pkg::REG_MOTOR_GAINS:   csr_prdata = motor_gains_ff;
         qxmm_pkg::REG_MOTOR_OFFSETS: csr_prdata = motor_offsets_ff;
         default:                     csr_prdata = 64'b0;
      endcase
   end

   // ------------------------------------------------------------------------
   // pipeline flow control
   // ------------------------------------------------------------------------
   logic [NS-1:0] vld_ff;
   logic [NS-1:0] vld_in;
   logic [NS-1:0] load;

   // a stage loads when empty or when its content moves on
   always_comb begin
      load[NS-1] = ~vld_ff[NS-1] | rsp_tready;
      for (int k = NS - 2; k >= 0; k--) begin
         load[k] = ~vld_ff[k] | load[k+1];
      end
   end

   always_comb begin
      vld_in[0] = load[0] ? req_tvalid : vld_ff[0];
      for (int k = 1; k < NS; k++) begin
         vld_in[k] = load[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_tready = load[0];

   // ------------------------------------------------------------------------
   // stage 1: pick the curve segment
   // ------------------------------------------------------------------------
   logic        [DW-1:0] in_thr;
   logic signed [15:0]   in_roll;
   logic signed [15:0]   in_pitch;
   logic signed [15:0]   in_yaw;
   logic                 seg_low;

   assign in_thr   = req_tdata[14:0];
   assign in_roll  = $signed(req_tdata[30:15]);
   assign in_pitch = $signed(req_tdata[46:31]);
   assign in_yaw   = $signed(req_tdata[62:47]);
   assign seg_low  = in_thr < {1'b0, mid_point_ff};

   logic signed [15:0]   s1_x_ff;
   logic signed [19:0]   s1_slope_ff;
   logic        [15:0]   s1_base_ff;
   logic        [DW-1:0] s1_thr_ff;
   logic signed [15:0]   s1_roll_ff;
   logic signed [15:0]   s1_pitch_ff;
   logic signed [15:0]   s1_yaw_ff;
   logic                 s1_armed_ff;

   always_ff @(posedge clock) begin
      if (load[0]) begin
         if (seg_low) begin
            s1_x_ff     <= $signed({1'b0, in_thr});
            s1_slope_ff <= $signed(low_slope_ff);
            s1_base_ff  <= start_factor_ff;
         end else begin
            s1_x_ff     <= $signed({1'b0, in_thr}) - $signed({2'b0, mid_point_ff});
            s1_slope_ff <= $signed(high_slope_ff);
            s1_base_ff  <= mid_factor_ff;
         end
         s1_thr_ff   <= in_thr;
         s1_roll_ff  <= in_roll;
         s1_pitch_ff <= in_pitch;
         s1_yaw_ff   <= in_yaw;
         s1_armed_ff <= req_tuser;
      end
   end

   // ------------------------------------------------------------------------
   // stage 2: slope product
   // ------------------------------------------------------------------------
   logic signed [35:0]   s2_prod_ff;
   logic        [15:0]   s2_base_ff;
   logic        [DW-1:0] s2_thr_ff;
   logic signed [15:0]   s2_roll_ff;
   logic signed [15:0]   s2_pitch_ff;
   logic signed [15:0]   s2_yaw_ff;
   logic                 s2_armed_ff;

   always_ff @(posedge clock) begin
      if (load[1]) begin
         s2_prod_ff  <= 36'(s1_x_ff) * 36'(s1_slope_ff);
         s2_base_ff  <= s1_base_ff;
         s2_thr_ff   <= s1_thr_ff;
         s2_roll_ff  <= s1_roll_ff;
         s2_pitch_ff <= s1_pitch_ff;
         s2_yaw_ff   <= s1_yaw_ff;
         s2_armed_ff <= s1_armed_ff;
      end
   end

   // ------------------------------------------------------------------------
   // stage 3: attenuation gain, floor shift of the product plus segment base
   // ------------------------------------------------------------------------
   logic signed [35:0] gain_sum;

   assign gain_sum = $signed({20'b0, s2_base_ff}) + (s2_prod_ff >>> FB);

   logic signed [23:0]   s3_gain_ff;
   logic        [DW-1:0] s3_thr_ff;
   logic signed [15:0]   s3_roll_ff;
   logic signed [15:0]   s3_pitch_ff;
   logic signed [15:0]   s3_yaw_ff;
   logic                 s3_armed_ff;

   always_ff @(posedge clock) begin
      if (load[2]) begin
         s3_gain_ff  <= $signed(gain_sum[23:0]);
         s3_thr_ff   <= s2_thr_ff;
         s3_roll_ff  <= s2_roll_ff;
         s3_pitch_ff <= s2_pitch_ff;
         s3_yaw_ff   <= s2_yaw_ff;
         s3_armed_ff <= s2_armed_ff;
      end
   end

   // ------------------------------------------------------------------------
   // stage 4: attenuate roll and pitch
   // ------------------------------------------------------------------------
   logic signed [39:0]   s4_rprod_ff;
   logic signed [39:0]   s4_pprod_ff;
   logic        [DW-1:0] s4_thr_ff;
   logic signed [15:0]   s4_yaw_ff;
   logic                 s4_armed_ff;

   always_ff @(posedge clock) begin
      if (load[3]) begin
         s4_rprod_ff <= 40'(s3_roll_ff) * 40'(s3_gain_ff);
         s4_pprod_ff <= 40'(s3_pitch_ff) * 40'(s3_gain_ff);
         s4_thr_ff   <= s3_thr_ff;
         s4_yaw_ff   <= s3_yaw_ff;
         s4_armed_ff <= s3_armed_ff;
      end
   end

   // ------------------------------------------------------------------------
   // stage 5: X-frame mix
   // ------------------------------------------------------------------------
   logic signed [39:0] r_sh;
   logic signed [39:0] p_sh;
   logic signed [27:0] mix_t;
   logic signed [27:0] mix_r;
   logic signed [27:0] mix_p;
   logic signed [27:0] mix_y;
   logic signed [27:0] mix_val [NM];

   always_comb begin
      r_sh       = s4_rprod_ff >>> FB;
      p_sh       = s4_pprod_ff >>> FB;
      mix_t      = $signed({13'b0, s4_thr_ff});
      mix_r      = $signed(r_sh[27:0]);
      mix_p      = $signed(p_sh[27:0]);
      mix_y      = 28'(s4_yaw_ff);
      mix_val[0] = mix_t + mix_r + mix_p + mix_y;
      mix_val[1] = mix_t - mix_r - mix_p + mix_y;
      mix_val[2] = mix_t + mix_r - mix_p - mix_y;
      mix_val[3] = mix_t - mix_r + mix_p - mix_y;
   end

   logic signed [27:0] s5_mix_ff [NM];
   logic               s5_armed_ff;

   always_ff @(posedge clock) begin
      if (load[4]) begin
         s5_mix_ff   <= mix_val;
         s5_armed_ff <= s4_armed_ff;
      end
   end

   // ------------------------------------------------------------------------
   // stage 6: per-motor calibration gain
   // ------------------------------------------------------------------------
   logic signed [44:0] s6_mprod_ff [NM];
   logic               s6_armed_ff;

   always_ff @(posedge clock) begin
      if (load[5]) begin
         for (int i = 0; i < NM; i++) begin
            s6_mprod_ff[i] <= 45'(s5_mix_ff[i]) *
                              $signed({29'b0, motor_gains_ff[16*i +: 16]});
         end
         s6_armed_ff <= s5_armed_ff;
      end
   end

   // ------------------------------------------------------------------------
   // stage 7: offset, clamp to 0..one, disarm override
   // ------------------------------------------------------------------------
   logic signed [44:0] cal_val [NM];
   logic [DW-1:0]      drive_in [NM];

   always_comb begin
      for (int i = 0; i < NM; i++) begin
         cal_val[i] = (s6_mprod_ff[i] >>> FB) +
                      45'($signed(motor_offsets_ff[16*i +: 16]));
         if (!s6_armed_ff) begin
            drive_in[i] = '0;
         end else if (cal_val[i] > $signed({30'b0, qxmm_pkg::DRIVE_ONE})) begin
            drive_in[i] = qxmm_pkg::DRIVE_ONE;
         end else if (cal_val[i] < 0) begin
            drive_in[i] = '0;
         end else begin
            drive_in[i] = cal_val[i][DW-1:0];
         end
      end
   end

   logic [DW-1:0] rsp_drive_ff [NM];
   logic          rsp_err_ff;

   always_ff @(posedge clock) begin
      if (load[6]) begin
         rsp_drive_ff <= drive_in;
         rsp_err_ff   <= ~s6_armed_ff;
      end
   end

   assign rsp_tvalid = vld_ff[NS-1];
   assign rsp_tuser  = rsp_err_ff;
   assign rsp_tdata  = {4'b0, rsp_drive_ff[3], rsp_drive_ff[2],
                        rsp_drive_ff[1], rsp_drive_ff[0]};

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   // pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (vld_ff == '0))
      else $error("pipeline not empty after reset");

   // req side only stalls when every stage is full and rsp is stalled
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> ((&vld_ff) && !rsp_tready))
      else $error("req stalled with room in the pipeline");

   // a disarmed beat carries zero drives
   a_disarm_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == 64'b0))
      else $error("disarmed beat with nonzero drive");

   // every drive stays within the clamp range
   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_drive_ff[0] <= qxmm_pkg::DRIVE_ONE) &&
                      (rsp_drive_ff[1] <= qxmm_pkg::DRIVE_ONE) &&
                      (rsp_drive_ff[2] <= qxmm_pkg::DRIVE_ONE) &&
                      (rsp_drive_ff[3] <= qxmm_pkg::DRIVE_ONE)))
      else $error("drive above full scale");

   // an accepted beat reaches the first stage
   a_accept_load: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> vld_ff[0])
      else $error("accepted beat lost at pipeline entry");

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for quad_x_motor_mixer_unit. Control samples go in as
// req beats and drive sets come back as rsp beats. A behavioral mixer kept
// in the bench predicts every drive set from a shadow copy of the csr
// registers. Directed samples cover the field extremes, both curve segments,
// a zero mid point, negative and large attenuation gains, calibration
// extremes and disarmed samples. Random phases follow, each with its own
// register setting. Both streams idle at random between beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

   localparam int    CYCLE_LIMIT    = 300000;
   localparam int    PHASE_COUNT    = 10;
   localparam int    PHASE_SAMPLES  = 110;
   localparam longint FX_ONE        = longint'(1) << qxmm_pkg::FRAC_BITS;

   // one control sample, throttle in the low bits
   typedef struct packed {
      logic               armed;
      logic signed [15:0] yaw;
      logic signed [15:0] pitch;
      logic signed [15:0] roll;
      logic [14:0]        throttle;
   } ctrl_sample_type;

   // one drive set, front left motor in the low bits
   typedef struct packed {
      logic                                                  disarmed;
      logic [qxmm_pkg::NUM_MOTORS-1:0][qxmm_pkg::DRIVE_W-1:0] drive;
   } drive_set_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // throttle, roll, pitch, yaw
   logic        req_tuser;   // armed
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;   // front_left, rear_right, rear_left, front_right
   logic        rsp_tuser;   // disarmed_error
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [5:0]  csr_paddr;
   logic [63:0] csr_pwdata;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   // shadow of the csr registers
   logic [15:0]        cfg_start_factor;
   logic [15:0]        cfg_mid_factor;
   logic [13:0]        cfg_mid_point;
   logic signed [19:0] cfg_low_slope;
   logic signed [19:0] cfg_high_slope;
   logic [63:0]        cfg_motor_gains;
   logic [63:0]        cfg_motor_offsets;

   drive_set_type pending_drives [$];
   int            error_count = 0;
   int            cycle_count = 0;
   int            rsp_hold    = 0;
   bit            quiet_run   = 1'b0;

   quad_x_motor_mixer_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // clock, 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // fixed point product, truncated toward minus infinity
   function automatic longint fx_mul(longint a, longint b);
      longint prod;
      prod = a * b;
      return prod >>> qxmm_pkg::FRAC_BITS;
   endfunction

   // behavioral mixer: attenuation curve, x-frame mix, calibration, clamp
   function automatic drive_set_type predict_drives(ctrl_sample_type s);
      longint        thr, att, r, p, y, g, o, v;
      longint        mix [qxmm_pkg::NUM_MOTORS];
      drive_set_type d;
      d = '0;
      if (!s.armed) begin
         d.disarmed = 1'b1;
         return d;
      end
      thr = longint'(s.throttle);
      if (thr < longint'(cfg_mid_point))
         att = longint'(cfg_start_factor) + fx_mul(thr, longint'(cfg_low_slope));
      else
         att = longint'(cfg_mid_factor) +
               fx_mul(thr - longint'(cfg_mid_point), longint'(cfg_high_slope));
      r = fx_mul(longint'(s.roll), att);
      p = fx_mul(longint'(s.pitch), att);
      y = longint'(s.yaw);
      mix[0] = thr + r + p + y;
      mix[1] = thr - r - p + y;
      mix[2] = thr + r - p - y;
      mix[3] = thr - r + p - y;
      for (int m = 0; m < qxmm_pkg::NUM_MOTORS; m++) begin
         g = longint'(cfg_motor_gains[16*m +: 16]);
         o = longint'($signed(cfg_motor_offsets[16*m +: 16]));
         v = fx_mul(mix[m], g) + o;
         if (v > FX_ONE)
            v = FX_ONE;
         else if (v < 0)
            v = 0;
         d.drive[m] = v[qxmm_pkg::DRIVE_W-1:0];
      end
      return d;
   endfunction

   function automatic ctrl_sample_type mk_sample(int thr, int roll, int pitch, int yaw,
                                                 bit armed);
      ctrl_sample_type s;
      s.throttle = 15'(thr);
      s.roll     = 16'(roll);
      s.pitch    = 16'(pitch);
      s.yaw      = 16'(yaw);
      s.armed    = armed;
      return s;
   endfunction

   // mostly armed, in-range samples with moderate attitude terms
   function automatic ctrl_sample_type random_sample();
      ctrl_sample_type s;
      s.armed    = ($urandom_range(0, 99) < 88);
      s.throttle = ($urandom_range(0, 4) != 0) ? 15'($urandom_range(0, 16384))
                                               : 15'($urandom());
      s.roll     = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 8192) - 4096)
                                              : 16'($urandom());
      s.pitch    = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 8192) - 4096)
                                              : 16'($urandom());
      s.yaw      = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 8192) - 4096)
                                              : 16'($urandom());
      return s;
   endfunction

   // one req beat after a random gap, prediction queued on acceptance
   task automatic send_sample(ctrl_sample_type s);
      int gap;
      gap = quiet_run ? 0 : $urandom_range(0, 7);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, s.yaw, s.pitch, s.roll, s.throttle};
      req_tuser  <= s.armed;
      do @(posedge clock); while (!req_tready);
      pending_drives.push_back(predict_drives(s));
   endtask

   // stop sending and wait until every drive set is back
   task automatic drain_pipeline();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_drives.size() != 0) @(posedge clock);
      repeat (qxmm_pkg::PIPE_STAGES + 2) @(posedge clock);
   endtask

   // csr write: setup then access, shadow updated at the write edge
   task automatic write_csr(qxmm_pkg::csr_index_type idx, logic [63:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= 6'(8 * int'(idx));
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         qxmm_pkg::REG_START_FACTOR:  cfg_start_factor  = value[15:0];
         qxmm_pkg::REG_MID_FACTOR:    cfg_mid_factor    = value[15:0];
         qxmm_pkg::REG_MID_POINT:     cfg_mid_point     = value[13:0];
         qxmm_pkg::REG_LOW_SLOPE:     cfg_low_slope     = value[19:0];
         qxmm_pkg::REG_HIGH_SLOPE:    cfg_high_slope    = value[19:0];
         qxmm_pkg::REG_MOTOR_GAINS:   cfg_motor_gains   = value;
         qxmm_pkg::REG_MOTOR_OFFSETS: cfg_motor_offsets = value;
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // result side: random stall after each beat
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold = rsp_hold - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic check_beat();
      drive_set_type                want;
      logic [qxmm_pkg::DRIVE_W-1:0] got;
      string                        motor_name [qxmm_pkg::NUM_MOTORS];
      motor_name = '{"front_left", "rear_right", "rear_left", "front_right"};
      if (pending_drives.size() == 0) begin
         error_count++;
         $display("%0t: unexpected rsp beat, data %h user %b", $time, rsp_tdata,
                  rsp_tuser);
      end else begin
         want = pending_drives.pop_front();
         for (int m = 0; m < qxmm_pkg::NUM_MOTORS; m++) begin
            got = rsp_tdata[qxmm_pkg::DRIVE_W*m +: qxmm_pkg::DRIVE_W];
            if (got !== want.drive[m]) begin
               error_count++;
               $display("%0t: %s_drive expected %0d actual %0d", $time,
                        motor_name[m], want.drive[m], got);
            end
         end
         if (rsp_tuser !== want.disarmed) begin
            error_count++;
            $display("%0t: disarmed_error expected %b actual %b", $time,
                     want.disarmed, rsp_tuser);
         end
      end
   endtask

   // compare every accepted rsp beat with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         check_beat();
         rsp_hold = quiet_run ? 0 : $urandom_range(0, 7);
      end
   end

   // default registers, field extremes and disarmed samples
   task automatic test_reset_defaults();
      send_sample(mk_sample(0, 0, 0, 0, 1'b1));
      send_sample(mk_sample(16384, 0, 0, 0, 1'b1));
      send_sample(mk_sample(8192, 32767, -32768, 0, 1'b1));
      send_sample(mk_sample(8191, -32768, 32767, 32767, 1'b1));
      send_sample(mk_sample(4096, 1000, -2000, -32768, 1'b1));
      send_sample(mk_sample(32767, -1, -1, -1, 1'b0));
      send_sample(mk_sample(0, 0, 0, 0, 1'b0));
   endtask

   // throttle above one and full-scale attitude terms
   task automatic test_field_extremes();
      send_sample(mk_sample(32767, 0, 0, 0, 1'b1));
      send_sample(mk_sample(32767, 32767, 32767, 32767, 1'b1));
      send_sample(mk_sample(16385, -32768, -32768, -32768, 1'b1));
      send_sample(mk_sample(21845, 10922, -21846, 5461, 1'b1));
   endtask

   // both curve segments, negative and large gain, odd mid points
   task automatic test_gain_curve();
      drain_pipeline();
      write_csr(qxmm_pkg::REG_START_FACTOR, 64'd32768);
      write_csr(qxmm_pkg::REG_MID_FACTOR, 64'd0);
      write_csr(qxmm_pkg::REG_MID_POINT, 64'd14746);
      write_csr(qxmm_pkg::REG_LOW_SLOPE, 64'(327680));
      write_csr(qxmm_pkg::REG_HIGH_SLOPE, 64'(-327680));
      send_sample(mk_sample(0, 8192, -8192, 0, 1'b1));
      send_sample(mk_sample(14745, 1000, 1000, 0, 1'b1));
      send_sample(mk_sample(14746, 1000, -1000, 0, 1'b1));
      send_sample(mk_sample(16384, 4000, 2000, 100, 1'b1));
      drain_pipeline();
      // zero mid point, upper segment everywhere
      write_csr(qxmm_pkg::REG_MID_POINT, 64'd0);
      send_sample(mk_sample(0, 4000, -3000, 0, 1'b1));
      send_sample(mk_sample(16384, -4000, 3000, 0, 1'b1));
      drain_pipeline();
      // mid point just below one, upper segment at full throttle
      write_csr(qxmm_pkg::REG_MID_POINT, 64'd16383);
      send_sample(mk_sample(16384, 2000, 2000, -2000, 1'b1));
   endtask

   // calibration gain and offset extremes per motor
   task automatic test_calibration();
      drain_pipeline();
      write_csr(qxmm_pkg::REG_MOTOR_GAINS, 64'hFFFF_0000_8000_4000);
      write_csr(qxmm_pkg::REG_MOTOR_OFFSETS, 64'h8000_7FFF_C000_2000);
      send_sample(mk_sample(8192, 0, 0, 0, 1'b1));
      send_sample(mk_sample(16384, 3000, -3000, 1500, 1'b1));
      send_sample(mk_sample(0, -3000, 3000, -1500, 1'b1));
   endtask

   task automatic write_all_csr(logic [15:0] start_f, logic [15:0] mid_f,
                                logic [13:0] mid_p, int low_s, int high_s,
                                logic [63:0] gains, logic [63:0] offsets);
      write_csr(qxmm_pkg::REG_START_FACTOR, 64'(start_f));
      write_csr(qxmm_pkg::REG_MID_FACTOR, 64'(mid_f));
      write_csr(qxmm_pkg::REG_MID_POINT, 64'(mid_p));
      write_csr(qxmm_pkg::REG_LOW_SLOPE, 64'(low_s));
      write_csr(qxmm_pkg::REG_HIGH_SLOPE, 64'(high_s));
      write_csr(qxmm_pkg::REG_MOTOR_GAINS, gains);
      write_csr(qxmm_pkg::REG_MOTOR_OFFSETS, offsets);
   endtask

   // phases of random samples, each under its own register setting
   task automatic test_random_phases();
      logic [63:0] gains, offsets;
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         drain_pipeline();
         case (ph)
            0: write_all_csr(qxmm_pkg::START_FACTOR_RST, qxmm_pkg::MID_FACTOR_RST,
                             qxmm_pkg::MID_POINT_RST,
                             int'($signed(qxmm_pkg::LOW_SLOPE_RST)),
                             int'($signed(qxmm_pkg::HIGH_SLOPE_RST)),
                             qxmm_pkg::MOTOR_GAINS_RST, qxmm_pkg::MOTOR_OFFSETS_RST);
            1: write_all_csr(16'd32768, 16'd32768, 14'd14746, 327680, 327680,
                             64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_7FFF_7FFF_7FFF);
            2: write_all_csr(16'd0, 16'd0, 14'd1638, -327680, -327680,
                             64'h0000_0000_0000_0000, 64'h8000_8000_8000_8000);
            default: begin
               for (int m = 0; m < qxmm_pkg::NUM_MOTORS; m++) begin
                  gains[16*m +: 16]   = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                        : 16'($urandom_range(14000, 18000));
                  offsets[16*m +: 16] = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                        : 16'($urandom_range(0, 4096) - 2048);
               end
               write_all_csr(16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768)),
                             14'($urandom_range(1638, 14746)),
                             int'($urandom_range(0, 655360)) - 327680,
                             int'($urandom_range(0, 655360)) - 327680,
                             gains, offsets);
            end
         endcase
         quiet_run = (ph == 3 || ph == 7);
         for (int n = 0; n < PHASE_SAMPLES; n++)
            send_sample(random_sample());
      end
      quiet_run = 1'b0;
   endtask

   initial begin
      int waited;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      rsp_tready  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      cfg_start_factor  = qxmm_pkg::START_FACTOR_RST;
      cfg_mid_factor    = qxmm_pkg::MID_FACTOR_RST;
      cfg_mid_point     = qxmm_pkg::MID_POINT_RST;
      cfg_low_slope     = qxmm_pkg::LOW_SLOPE_RST;
      cfg_high_slope    = qxmm_pkg::HIGH_SLOPE_RST;
      cfg_motor_gains   = qxmm_pkg::MOTOR_GAINS_RST;
      cfg_motor_offsets = qxmm_pkg::MOTOR_OFFSETS_RST;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_field_extremes();
      test_gain_curve();
      test_calibration();
      test_random_phases();

      // wait out the last drive sets, then watch for stray beats
      @(negedge clock);
      req_tvalid <= 1'b0;
      waited = 0;
      while (pending_drives.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (qxmm_pkg::PIPE_STAGES + 4) @(posedge clock);
      if (pending_drives.size() != 0) begin
         error_count++;
         $display("%0t: %0d drive sets never arrived", $time, pending_drives.size());
      end

      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

@@ files.f @@
rtl/qxmm_pkg.sv
rtl/quad_x_motor_mixer_unit.sv
test/testbench.sv
